### src/polygon_outline_miter_extrude_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polygon outline extruder
// Shared property forms; each expects clk and rst in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef POLYGON_OUTLINE_MITER_EXTRUDE_CORE_ASSERT_SVH
`define POLYGON_OUTLINE_MITER_EXTRUDE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/pomx_pkg.sv
// ----------------------------------------------------------------------------
// pomx_pkg
// Shared types and constants of the polygon outline miter extruder.
// ----------------------------------------------------------------------------
`default_nettype none

package pomx_pkg;

  localparam int COORD_W = 24;
  localparam int NORM_W  = 18;
  localparam int IDX_W   = 12;
  localparam int THICK_W = 16;

  localparam logic [THICK_W-1:0] THICK_RESET = 16'd256;
  localparam logic [IDX_W-1:0]   IDX_TOP     = 12'd4095;
  localparam logic [IDX_W-1:0]   MIN_POINTS  = 12'd3;

  // Unit length of a normal component in Q2.16.
  localparam logic [16:0] UNIT_Q16 = 17'd65536;
  // One in Q32 for the miter factor, and the factor below which it counts as zero.
  localparam logic signed [34:0] ONE_Q32   = 35'sh1_0000_0000;
  localparam logic signed [34:0] REV_LIMIT = 35'sd262144;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
  } norm_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      rev;
  } miter_res_t;

endpackage

`default_nettype wire

### src/pomx_if.sv
// ----------------------------------------------------------------------------
// pomx_if
// Valid/ready channels for vertices in and outline points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pomx_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic               last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

interface pomx_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        vertex_index;
  logic signed [23:0] base_x;
  logic signed [23:0] base_y;
  logic signed [23:0] outer_x;
  logic signed [23:0] outer_y;
  logic               reversal_flag;
  logic               too_few;
  logic               last_result;

  modport source (output valid, output vertex_index, output base_x, output base_y,
                  output outer_x, output outer_y, output reversal_flag,
                  output too_few, output last_result, input ready);
  modport sink (input valid, input vertex_index, input base_x, input base_y,
                input outer_x, input outer_y, input reversal_flag,
                input too_few, input last_result, output ready);
endinterface

`default_nettype wire

### src/polygon_outline_miter_extrude_core.sv
// ----------------------------------------------------------------------------
// polygon_outline_miter_extrude_core
// Takes a closed polygon one vertex per transfer and returns, for each
// vertex, the vertex and its miter-extruded outer point at the set
// thickness. Vertex k comes out when vertex k+1 arrives; the last vertex
// releases vertex n-2, vertex n-1 and then vertex 0. One vertex is worked
// on at a time. For a middle vertex the edge normal needs up to 24
// normalizing shifts, a 26-step square root and a 17-step divide, and
// the miter unit a 50-step divide; a zero miter factor skips that
// divide. The last vertex runs one more normal and two miter passes,
// and any result can wait for the receiver.
// A finished result waits in the output register while the next vertex is
// taken. Polygons of fewer than three vertices give one too_few result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_outline_miter_extrude_core_assert.svh"

module polygon_outline_miter_extrude_core
  import pomx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [THICK_W-1:0] cfg_wdata,
  pomx_in_if.sink                 points,
  pomx_out_if.source              results
);

  typedef enum logic [2:0] {
    S_IDLE, S_NRM, S_EMIT, S_MWAIT, S_OUTW, S_END
  } state_t;

  typedef enum logic [1:0] {
    PH_MID, PH_TAIL, PH_WRAP, PH_FEW
  } phase_t;

  state_t             state;
  phase_t             phase;
  logic               nrm_close;
  logic [THICK_W-1:0] thickness;
  point_t             first_point, newer_point, cur_p;
  norm_t              first_n, last_n, n_cur;
  logic [IDX_W-1:0]   point_count, c_old, c_new;
  logic               is_last;
  point_t             nrm_a, nrm_b;
  logic               nrm_start, mit_start;
  logic [IDX_W-1:0]   em_idx;
  point_t             em_p;
  norm_t              em_n1, em_n2;
  logic               em_last;
  logic               res_valid;
  logic [IDX_W-1:0]   res_idx;
  point_t             res_base;
  miter_res_t         res_outer;
  logic               res_few, res_last;

  logic               nrm_done, mit_done;
  norm_t              nrm_n;
  miter_res_t         mit_res;
  logic               out_free;
  point_t             in_p;

  pomx_normal u_normal (
    .clk   (clk),
    .rst   (rst),
    .start (nrm_start),
    .a     (nrm_a),
    .b     (nrm_b),
    .done  (nrm_done),
    .n     (nrm_n)
  );

  pomx_miter u_miter (
    .clk       (clk),
    .rst       (rst),
    .start     (mit_start),
    .p         (em_p),
    .n1        (em_n1),
    .n2        (em_n2),
    .thickness (thickness),
    .done      (mit_done),
    .res       (mit_res)
  );

  // Handshake and output drive.
  assign points.ready          = (state == S_IDLE);
  assign in_p.x                = points.point_x;
  assign in_p.y                = points.point_y;
  assign out_free              = !res_valid || results.ready;
  assign results.valid         = res_valid;
  assign results.vertex_index  = res_idx;
  assign results.base_x        = res_base.x;
  assign results.base_y        = res_base.y;
  assign results.outer_x       = res_outer.x;
  assign results.outer_y       = res_outer.y;
  assign results.reversal_flag = res_outer.rev;
  assign results.too_few       = res_few;
  assign results.last_result   = res_last;

  // Thickness register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thickness <= THICK_RESET;
    end else if (cfg_we) begin
      thickness <= cfg_wdata;
    end
  end

  // Vertex sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_MID;
      nrm_start   <= 1'b0;
      mit_start   <= 1'b0;
      res_valid   <= 1'b0;
      point_count <= '0;
      first_point <= '0;
      newer_point <= '0;
      first_n     <= '0;
      last_n      <= '0;
    end else begin
      nrm_start <= 1'b0;
      mit_start <= 1'b0;
      if (results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (points.valid) begin
            cur_p   <= in_p;
            is_last <= points.last_point;
            c_old   <= point_count;
            c_new   <= (point_count < IDX_TOP) ? point_count + 12'd1 : point_count;
            if (point_count == 12'd0) begin
              first_point <= in_p;
              state       <= S_END;
            end else begin
              nrm_a     <= newer_point;
              nrm_b     <= in_p;
              nrm_close <= 1'b0;
              nrm_start <= 1'b1;
              state     <= S_NRM;
            end
          end
        end
        S_NRM: begin
          if (nrm_done) begin
            n_cur <= nrm_n;
            if (nrm_close) begin
              em_idx  <= c_new - 12'd1;
              em_p    <= cur_p;
              em_n1   <= last_n;
              em_n2   <= nrm_n;
              em_last <= 1'b0;
              phase   <= PH_TAIL;
              state   <= S_EMIT;
            end else if (c_old == 12'd1) begin
              first_n <= nrm_n;
              last_n  <= nrm_n;
              state   <= S_END;
            end else begin
              em_idx  <= c_old - 12'd1;
              em_p    <= newer_point;
              em_n1   <= last_n;
              em_n2   <= nrm_n;
              em_last <= 1'b0;
              phase   <= PH_MID;
              state   <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          mit_start <= 1'b1;
          state     <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mit_done) begin
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (phase == PH_FEW) begin
              res_idx   <= '0;
              res_base  <= '0;
              res_outer <= '0;
              res_few   <= 1'b1;
              res_last  <= 1'b1;
            end else begin
              res_idx   <= em_idx;
              res_base  <= em_p;
              res_outer <= mit_res;
              res_few   <= 1'b0;
              res_last  <= em_last;
            end
            case (phase)
              PH_MID: begin
                last_n <= n_cur;
                state  <= S_END;
              end
              PH_TAIL: begin
                em_idx  <= '0;
                em_p    <= first_point;
                em_n1   <= n_cur;
                em_n2   <= first_n;
                em_last <= 1'b1;
                phase   <= PH_WRAP;
                state   <= S_EMIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_END: begin
          newer_point <= cur_p;
          if (!is_last) begin
            point_count <= c_new;
            state       <= S_IDLE;
          end else begin
            point_count <= '0;
            if (c_new < MIN_POINTS) begin
              phase <= PH_FEW;
              state <= S_OUTW;
            end else begin
              nrm_a     <= cur_p;
              nrm_b     <= first_point;
              nrm_close <= 1'b1;
              nrm_start <= 1'b1;
              state     <= S_NRM;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on sequencing and on the closing results.
  `POMX_ASSERT_NEXT(a_accept_busy, points.valid && points.ready, !points.ready, "vertex taken while busy")
  `POMX_ASSERT_NOW(a_nrm_wait, nrm_done, state == S_NRM, "normal result with no waiting vertex")
  `POMX_ASSERT_NOW(a_mit_wait, mit_done, state == S_MWAIT, "miter result with no waiting vertex")
  `POMX_ASSERT_NOW(a_few_form, results.valid && results.too_few, results.last_result && results.vertex_index == 12'd0, "malformed too_few result")
  `POMX_ASSERT_NOW(a_wrap_index, results.valid && results.last_result, results.vertex_index == 12'd0, "closing result is not vertex zero")

endmodule

`default_nettype wire

### src/pomx_normal.sv
// ----------------------------------------------------------------------------
// pomx_normal
// Unit normal of the edge a->b: bit-serial normalize, two-bit-per-step
// square root and bit-serial division of both components.
// ----------------------------------------------------------------------------
`default_nettype none

module pomx_normal
  import pomx_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire point_t a,
  input  wire point_t b,
  output logic        done,
  output norm_t       n
);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQA, N_SQB, N_ROOT, N_LOAD, N_DIV
  } nstate_t;

  nstate_t            state;
  logic [24:0]        ux, uy;
  logic               negx, negy;
  logic [51:0]        sumsq;
  logic [25:0]        root;
  logic [27:0]        rem;
  logic [4:0]         step;
  logic [25:0]        remx, remy;
  logic [16:0]        dlx, dly;
  logic [16:0]        qx, qy;

  logic signed [24:0] ex, ey;
  logic [24:0]        mx, my;
  logic [24:0]        sq_op;
  logic [49:0]        sq_prod;
  logic [29:0]        rt, trial, rdiff;
  logic               rge;
  logic [41:0]        dvx, dvy;
  logic [26:0]        rtx, rty, dfx, dfy;
  logic               gex, gey;
  logic [16:0]        qx_next, qy_next;

  // Cap at one and apply the sign of the edge component.
  function automatic logic signed [17:0] signed_norm(input logic [16:0] q,
                                                     input logic neg);
    logic [16:0]        c;
    logic signed [17:0] v;
    c = (q > UNIT_Q16) ? UNIT_Q16 : q;
    v = signed'({1'b0, c});
    return neg ? -v : v;
  endfunction

  // Edge vector and its magnitudes.
  assign ex = 25'(a.y) - 25'(b.y);
  assign ey = 25'(b.x) - 25'(a.x);
  assign mx = ex[24] ? unsigned'(-ex) : unsigned'(ex);
  assign my = ey[24] ? unsigned'(-ey) : unsigned'(ey);

  // One squarer, used for each component in turn.
  assign sq_op   = (state == N_SQA) ? ux : uy;
  assign sq_prod = sq_op * sq_op;

  // Square root step: two radicand bits per cycle.
  assign rt    = {rem, sumsq[51:50]};
  assign trial = {2'b00, root, 2'b01};
  assign rge   = (rt >= trial);
  assign rdiff = rt - trial;

  // Rounded dividends for both components.
  assign dvx = {1'b0, ux, 16'h0000} + {17'h00000, root[25:1]};
  assign dvy = {1'b0, uy, 16'h0000} + {17'h00000, root[25:1]};

  // Restoring division step, one quotient bit per cycle.
  assign rtx     = {remx, dlx[16]};
  assign rty     = {remy, dly[16]};
  assign gex     = (rtx >= {1'b0, root});
  assign gey     = (rty >= {1'b0, root});
  assign dfx     = rtx - {1'b0, root};
  assign dfy     = rty - {1'b0, root};
  assign qx_next = {qx[15:0], gex};
  assign qy_next = {qy[15:0], gey};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            ux   <= mx;
            uy   <= my;
            negx <= ex[24];
            negy <= ey[24];
            if (mx == 25'd0 && my == 25'd0) begin
              n     <= '0;
              done  <= 1'b1;
            end else begin
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (!(ux[24] | uy[24])) begin
            ux <= {ux[23:0], 1'b0};
            uy <= {uy[23:0], 1'b0};
          end else begin
            state <= N_SQA;
          end
        end
        N_SQA: begin
          sumsq <= {2'b00, sq_prod};
          state <= N_SQB;
        end
        N_SQB: begin
          sumsq <= sumsq + {2'b00, sq_prod};
          root  <= '0;
          rem   <= '0;
          step  <= '0;
          state <= N_ROOT;
        end
        N_ROOT: begin
          rem   <= rge ? rdiff[27:0] : rt[27:0];
          root  <= {root[24:0], rge};
          sumsq <= {sumsq[49:0], 2'b00};
          step  <= step + 5'd1;
          if (step == 5'd25) begin
            state <= N_LOAD;
          end
        end
        N_LOAD: begin
          remx  <= {1'b0, dvx[41:17]};
          remy  <= {1'b0, dvy[41:17]};
          dlx   <= dvx[16:0];
          dly   <= dvy[16:0];
          qx    <= '0;
          qy    <= '0;
          step  <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          remx <= gex ? dfx[25:0] : rtx[25:0];
          remy <= gey ? dfy[25:0] : rty[25:0];
          dlx  <= {dlx[15:0], 1'b0};
          dly  <= {dly[15:0], 1'b0};
          qx   <= qx_next;
          qy   <= qy_next;
          step <= step + 5'd1;
          if (step == 5'd16) begin
            n.x   <= signed_norm(qx_next, negx);
            n.y   <= signed_norm(qy_next, negy);
            done  <= 1'b1;
            state <= N_IDLE;
          end
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/pomx_miter.sv
// ----------------------------------------------------------------------------
// pomx_miter
// Miter factor, scaled offset and outer point of one vertex, with a
// bit-serial divider for both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module pomx_miter
  import pomx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire point_t             p,
  input  wire norm_t              n1,
  input  wire norm_t              n2,
  input  wire logic [THICK_W-1:0] thickness,
  output logic                    done,
  output miter_res_t              res
);

  typedef enum logic [2:0] {
    M_IDLE, M_DOTX, M_DOTY, M_NUMX, M_NUMY, M_LOAD, M_DIV, M_FIN
  } mstate_t;

  mstate_t            state;
  logic signed [18:0] sx, sy;
  logic signed [35:0] dot;
  logic signed [34:0] f;
  logic [34:0]        fdiv;
  logic signed [35:0] numx, numy;
  logic               rev;
  logic [34:0]        remx, remy;
  logic [49:0]        dlx, dly;
  logic [32:0]        qx, qy;
  logic [5:0]         step;

  logic signed [18:0] ma, mb;
  logic signed [37:0] prod;
  logic               rev_c;
  logic [35:0]        magx, magy;
  logic [49:0]        dvx, dvy;
  logic [35:0]        rtx, rty, dfx, dfy;
  logic               gex, gey;

  // Outer coordinate: saturated sum, or a pinned value for a zero factor.
  function automatic logic signed [23:0] outer_coord(input logic signed [23:0] pc,
                                                     input logic signed [35:0] num,
                                                     input logic [32:0] q,
                                                     input logic rv);
    logic signed [35:0] off;
    logic signed [35:0] sum;
    off = signed'({3'b000, q});
    if (num < 0) begin
      off = -off;
    end
    sum = 36'(pc) + off;
    if (rv) begin
      if (num > 0) begin
        return COORD_MAX;
      end else if (num < 0) begin
        return COORD_MIN;
      end
      return pc;
    end
    if (sum > 36'(COORD_MAX)) begin
      return COORD_MAX;
    end
    if (sum < 36'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return signed'(sum[23:0]);
  endfunction

  // One shared multiplier for the dot product and the two numerators.
  always_comb begin
    case (state)
      M_DOTX: begin
        ma = 19'(n1.x);
        mb = 19'(n2.x);
      end
      M_DOTY: begin
        ma = 19'(n1.y);
        mb = 19'(n2.y);
      end
      M_NUMX: begin
        ma = sx;
        mb = signed'({3'b000, thickness});
      end
      M_NUMY: begin
        ma = sy;
        mb = signed'({3'b000, thickness});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign prod = ma * mb;

  // Dividend setup: magnitude shifted up, plus half the factor for rounding.
  assign rev_c = (f < REV_LIMIT);
  assign magx  = numx[35] ? unsigned'(-numx) : unsigned'(numx);
  assign magy  = numy[35] ? unsigned'(-numy) : unsigned'(numy);
  assign dvx   = {1'b0, magx[32:0], 16'h0000} + {16'h0000, f[34:1]};
  assign dvy   = {1'b0, magy[32:0], 16'h0000} + {16'h0000, f[34:1]};

  // Restoring division step for both axes.
  assign rtx = {remx, dlx[49]};
  assign rty = {remy, dly[49]};
  assign gex = (rtx >= {1'b0, fdiv});
  assign gey = (rty >= {1'b0, fdiv});
  assign dfx = rtx - {1'b0, fdiv};
  assign dfy = rty - {1'b0, fdiv};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            sx    <= 19'(n1.x) + 19'(n2.x);
            sy    <= 19'(n1.y) + 19'(n2.y);
            state <= M_DOTX;
          end
        end
        M_DOTX: begin
          dot   <= signed'(prod[35:0]);
          state <= M_DOTY;
        end
        M_DOTY: begin
          f     <= ONE_Q32 + 35'(dot) + 35'(prod);
          state <= M_NUMX;
        end
        M_NUMX: begin
          numx  <= signed'(prod[35:0]);
          state <= M_NUMY;
        end
        M_NUMY: begin
          numy  <= signed'(prod[35:0]);
          state <= M_LOAD;
        end
        M_LOAD: begin
          rev  <= rev_c;
          fdiv <= unsigned'(f);
          remx <= '0;
          remy <= '0;
          dlx  <= dvx;
          dly  <= dvy;
          qx   <= '0;
          qy   <= '0;
          step <= '0;
          state <= rev_c ? M_FIN : M_DIV;
        end
        M_DIV: begin
          remx <= gex ? dfx[34:0] : rtx[34:0];
          remy <= gey ? dfy[34:0] : rty[34:0];
          dlx  <= {dlx[48:0], 1'b0};
          dly  <= {dly[48:0], 1'b0};
          qx   <= {qx[31:0], gex};
          qy   <= {qy[31:0], gey};
          step <= step + 6'd1;
          if (step == 6'd49) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          res.x   <= outer_coord(p.x, numx, qx, rev);
          res.y   <= outer_coord(p.y, numy, qy, rev);
          res.rev <= rev;
          done    <= 1'b1;
          state   <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
